// ===== src/rcp_pkg.sv =====
// ---------------------------------------------------------------------------
// rcp_pkg
// shared types and constants of the riffle and cut permuter
// ---------------------------------------------------------------------------
`default_nettype none

package rcp_pkg;

  localparam int MAX_HALF_DEF = 128;

  localparam int MODE_W = 2;
  localparam int AMT_W  = 9;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 9;
  localparam int HC_W   = 8;
  localparam int CNT_W  = $clog2(POS_W);

  localparam logic [HC_W-1:0] HC_RESET = 8'd128;

  localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_PASS,
    ST_MOD,
    ST_FETCH,
    ST_DATA
  } state_t;

  typedef enum logic [1:0] {
    PASS_IDENT,
    PASS_RIFFLE,
    PASS_CUT
  } pass_kind_t;

  typedef struct packed {
    logic       start;
    pass_kind_t kind;
  } pass_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

`default_nettype wire

// ===== src/rcp_ram.sv =====
// ---------------------------------------------------------------------------
// rcp_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module rcp_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rcp_mod.sv =====
// ---------------------------------------------------------------------------
// rcp_mod
// position modulo deck size, restoring remainder, one bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module rcp_mod #(
  parameter int CW = 9,
  parameter int AW = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rcp_pkg::POS_W-1:0] pos,
  input  wire logic [CW-1:0]             total,
  output rcp_pkg::eng_stat_t             stat,
  output logic      [AW-1:0]             rem
);

  logic [CW-1:0]               r;
  logic [CW-1:0]               r_next;
  logic [rcp_pkg::POS_W-1:0]   p;
  logic [rcp_pkg::CNT_W-1:0]   cnt;
  logic                        busy;
  logic                        done;
  logic [CW:0]                 t;
  logic [CW:0]                 t_sub;

  always_comb begin
    t      = {r, p[rcp_pkg::POS_W-1]};
    t_sub  = t - {1'b0, total};
    r_next = (t >= {1'b0, total}) ? t_sub[CW-1:0] : t[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= '0;
      p   <= pos;
      cnt <= rcp_pkg::CNT_W'(rcp_pkg::POS_W - 1);
    end else if (busy) begin
      r   <= r_next;
      p   <= p << 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign rem       = r[AW-1:0];

endmodule

`default_nettype wire

// ===== src/rcp_pass.sv =====
// ---------------------------------------------------------------------------
// rcp_pass
// deck sweep: read source entry, write destination entry in the next cycle, not later
// ---------------------------------------------------------------------------
`default_nettype none

module rcp_pass #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rcp_pkg::pass_cmd_t        cmd,
  input  wire logic [CW-1:0]             half,
  input  wire logic [CW-1:0]             total,
  input  wire logic [CW-1:0]             k,
  input  wire logic [rcp_pkg::VAL_W-1:0] rdata,
  output rcp_pkg::eng_stat_t             stat,
  output logic      [AW-1:0]             raddr,
  output logic                           wr_en,
  output logic      [AW-1:0]             waddr,
  output logic      [rcp_pkg::VAL_W-1:0] wdata
);

  localparam int SW = (CW > rcp_pkg::VAL_W) ? CW : rcp_pkg::VAL_W;

  logic [CW-1:0] i;
  logic [CW-1:0] s;
  logic [CW-1:0] s_inc;
  logic [CW-1:0] src;
  logic          busy;
  logic          last;
  logic          wr_last;
  logic [SW-1:0] ident;

  assign last  = (i == CW'(DEPTH - 1));
  assign s_inc = s + 1'b1;

  always_comb begin
    src = i;
    if (i < total) begin
      unique case (cmd.kind)
        rcp_pkg::PASS_RIFFLE: src = i[0] ? (half + (i >> 1)) : (i >> 1);
        rcp_pkg::PASS_CUT:    src = s;
        default:              src = i;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      wr_en   <= 1'b0;
      wr_last <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
      wr_en   <= busy;
      wr_last <= busy && last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i <= '0;
      s <= k;
    end else if (busy) begin
      i <= i + 1'b1;
      s <= (s_inc == total) ? '0 : s_inc;
    end
    waddr <= i[AW-1:0];
  end

  assign ident = SW'(waddr) + SW'(1);
  assign wdata = (cmd.kind == rcp_pkg::PASS_IDENT) ? ident[rcp_pkg::VAL_W-1:0] : rdata;
  assign raddr = src[AW-1:0];

  assign stat.busy = busy;
  assign stat.done = wr_en && wr_last;

endmodule

`default_nettype wire

// ===== src/riffle_and_cut_permuter.sv =====
// ---------------------------------------------------------------------------
// riffle_and_cut_permuter
// deck of 2n entries in two ping-pong rams; start, riffle, cut and read
//
//   channel      signals                          direction  content
//   item         item_valid item_stall            in         mode amount position
//   result       result_valid result_stall        out        card_value
//   half_count   half_count_we half_count_data    in         entries per half
//
// start and shuffle words sweep all 2*MAX_HALF entries, one per cycle through
// the ram ports. a cut past the deck or mode 3 is accepted and does nothing.
// a read word runs the remainder in ST_MOD, then reads the ram in ST_FETCH and ST_DATA.
// after reset an identity sweep of all 2*MAX_HALF entries runs with item_stall high.
// a waiting result word does not hold back the next item until a new read is done.
// ---------------------------------------------------------------------------
`default_nettype none

module riffle_and_cut_permuter #(
  parameter int MAX_HALF = rcp_pkg::MAX_HALF_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic [rcp_pkg::MODE_W-1:0] mode,
  input  wire logic [rcp_pkg::AMT_W-1:0]  amount,
  input  wire logic [rcp_pkg::POS_W-1:0]  position,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic      [rcp_pkg::VAL_W-1:0]  card_value,
  input  wire logic                       half_count_we,
  input  wire logic [rcp_pkg::HC_W-1:0]   half_count_data
);

  localparam int DEPTH = 2 * MAX_HALF;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int WW    = (CW > rcp_pkg::HC_W) ? CW : rcp_pkg::HC_W;
  localparam int KW    = (CW > rcp_pkg::AMT_W) ? CW : rcp_pkg::AMT_W;

  rcp_pkg::state_t      state;
  rcp_pkg::state_t      state_next;
  rcp_pkg::pass_kind_t  kind;
  rcp_pkg::pass_kind_t  kind_next;
  rcp_pkg::pass_cmd_t   cmd;
  rcp_pkg::eng_stat_t   pass_stat;
  rcp_pkg::eng_stat_t   mod_stat;

  logic [rcp_pkg::HC_W-1:0]  hc;
  logic [WW-1:0]             half_w;
  logic [CW-1:0]             half;
  logic [CW-1:0]             total;
  logic [CW-1:0]             k;
  logic                      cut_ok;
  logic                      accept;
  logic                      mod_start;
  logic                      cur;
  logic                      load_out;

  logic [AW-1:0]             pass_raddr;
  logic [AW-1:0]             rem;
  logic [AW-1:0]             raddr;
  logic                      wr_en;
  logic [AW-1:0]             waddr;
  logic [rcp_pkg::VAL_W-1:0] wdata;
  logic                      wr_bank;
  logic [rcp_pkg::VAL_W-1:0] rdata0;
  logic [rcp_pkg::VAL_W-1:0] rdata1;
  logic [rcp_pkg::VAL_W-1:0] rdata;

  // active half, clamped to 1..MAX_HALF
  always_comb begin
    half_w = WW'(hc);
    if (hc == '0) begin
      half_w = WW'(1);
    end else if (WW'(hc) > WW'(MAX_HALF)) begin
      half_w = WW'(MAX_HALF);
    end
  end

  assign half   = half_w[CW-1:0];
  assign total  = {half[CW-2:0], 1'b0};
  assign cut_ok = (KW'(amount) < KW'(total));
  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hc <= rcp_pkg::HC_RESET;
    end else if (half_count_we) begin
      hc <= half_count_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcp_pkg::ST_LAUNCH;
      kind  <= rcp_pkg::PASS_IDENT;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k <= CW'(amount);
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    item_stall = 1'b1;
    cmd.start  = 1'b0;
    cmd.kind   = kind;
    mod_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      rcp_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          priority if (mode == rcp_pkg::MODE_START) begin
            kind_next  = rcp_pkg::PASS_IDENT;
            state_next = rcp_pkg::ST_LAUNCH;
          end else if (mode == rcp_pkg::MODE_SHUFFLE) begin
            if (amount == '0) begin
              kind_next  = rcp_pkg::PASS_RIFFLE;
              state_next = rcp_pkg::ST_LAUNCH;
            end else if (cut_ok) begin
              kind_next  = rcp_pkg::PASS_CUT;
              state_next = rcp_pkg::ST_LAUNCH;
            end
          end else if (mode == rcp_pkg::MODE_READ) begin
            mod_start  = 1'b1;
            state_next = rcp_pkg::ST_MOD;
          end else begin
            state_next = rcp_pkg::ST_IDLE;
          end
        end
      end
      rcp_pkg::ST_LAUNCH: begin
        cmd.start  = 1'b1;
        state_next = rcp_pkg::ST_PASS;
      end
      rcp_pkg::ST_PASS: begin
        if (pass_stat.done) begin
          state_next = rcp_pkg::ST_IDLE;
        end
      end
      rcp_pkg::ST_MOD: begin
        if (mod_stat.done) begin
          state_next = rcp_pkg::ST_FETCH;
        end
      end
      rcp_pkg::ST_FETCH: begin
        state_next = rcp_pkg::ST_DATA;
      end
      rcp_pkg::ST_DATA: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = rcp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rcp_pkg::ST_IDLE;
      end
    endcase
  end

  // deck lives in bank cur; a shuffle writes the other bank and then flips
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= 1'b0;
    end else if (pass_stat.done && (kind != rcp_pkg::PASS_IDENT)) begin
      cur <= ~cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      card_value <= rdata;
    end
  end

  assign wr_bank = (kind == rcp_pkg::PASS_IDENT) ? cur : ~cur;
  assign raddr   = ((state == rcp_pkg::ST_FETCH) || (state == rcp_pkg::ST_DATA)) ? rem
                                                                                  : pass_raddr;
  assign rdata   = cur ? rdata1 : rdata0;

  rcp_pass #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_pass (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .half  (half),
    .total (total),
    .k     (k),
    .rdata (rdata),
    .stat  (pass_stat),
    .raddr (pass_raddr),
    .wr_en (wr_en),
    .waddr (waddr),
    .wdata (wdata)
  );

  rcp_mod #(
    .CW (CW),
    .AW (AW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .pos   (position),
    .total (total),
    .stat  (mod_stat),
    .rem   (rem)
  );

  rcp_ram #(
    .WIDTH (rcp_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (wr_en && !wr_bank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  rcp_ram #(
    .WIDTH (rcp_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (wr_en && wr_bank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for riffle_and_cut_permuter: a queue-fed driver offers
// start, shuffle, read and unused words in random bursts while the receiver
// stalls on its own pattern; a local deck model predicts every card_value,
// and the half count is changed between phases while the block is idle
// ---------------------------------------------------------------------------

module tb;

  localparam logic [rcp_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int DECK_DEPTH     = 2 * rcp_pkg::MAX_HALF_DEF;
  localparam int DRAIN_CYCLES   = DECK_DEPTH + 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 500;
  localparam int PHASE_WORDS    = 140;
  localparam int PHASE_COUNT    = 10;

  typedef struct {
    logic [rcp_pkg::MODE_W-1:0] mode;
    logic [rcp_pkg::AMT_W-1:0]  amount;
    logic [rcp_pkg::POS_W-1:0]  position;
  } deck_word_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_stall;
  logic [rcp_pkg::MODE_W-1:0]  mode = '0;
  logic [rcp_pkg::AMT_W-1:0]   amount = '0;
  logic [rcp_pkg::POS_W-1:0]   position = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  logic [rcp_pkg::VAL_W-1:0]   card_value;
  logic                        half_count_we = 1'b0;
  logic [rcp_pkg::HC_W-1:0]    half_count_data = '0;

  deck_word_t                  pending_words[$];
  logic [rcp_pkg::VAL_W-1:0]   expected_cards[$];
  logic [rcp_pkg::VAL_W-1:0]   deck_model[DECK_DEPTH];
  logic [rcp_pkg::HC_W-1:0]    half_model;
  int                          error_count = 0;
  int                          cards_seen = 0;

  riffle_and_cut_permuter dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .mode            (mode),
    .amount          (amount),
    .position        (position),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .card_value      (card_value),
    .half_count_we   (half_count_we),
    .half_count_data (half_count_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_half();
    if (half_model == 0) return 1;
    if (int'(half_model) > rcp_pkg::MAX_HALF_DEF) return rcp_pkg::MAX_HALF_DEF;
    return int'(half_model);
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < DECK_DEPTH; i++) deck_model[i] = rcp_pkg::VAL_W'(i + 1);
  endfunction

  function automatic void update_deck_model(logic [rcp_pkg::MODE_W-1:0] m,
                                            logic [rcp_pkg::AMT_W-1:0] a,
                                            logic [rcp_pkg::POS_W-1:0] p);
    logic [rcp_pkg::VAL_W-1:0] next_deck[DECK_DEPTH];
    int h;
    int total;
    int src;
    h = active_half();
    total = 2 * h;
    next_deck = deck_model;
    case (m)
      rcp_pkg::MODE_START: begin
        load_identity();
      end
      rcp_pkg::MODE_SHUFFLE: begin
        if (a == 0) begin
          for (int j = 0; j < h; j++) begin
            next_deck[2*j]   = deck_model[j];
            next_deck[2*j+1] = deck_model[h+j];
          end
          deck_model = next_deck;
        end else if (int'(a) < total) begin
          for (int i = 0; i < total; i++) begin
            src = i + int'(a);
            if (src >= total) src -= total;
            next_deck[i] = deck_model[src];
          end
          deck_model = next_deck;
        end
      end
      rcp_pkg::MODE_READ: begin
        expected_cards = {expected_cards, deck_model[int'(p) % total]};
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void push_word(logic [rcp_pkg::MODE_W-1:0] m,
                                    logic [rcp_pkg::AMT_W-1:0] a,
                                    logic [rcp_pkg::POS_W-1:0] p);
    deck_word_t w;
    w.mode = m;
    w.amount = a;
    w.position = p;
    pending_words = {pending_words, w};
  endfunction

  function automatic deck_word_t random_deck_word();
    deck_word_t w;
    int h;
    int r;
    int sub;
    h = active_half();
    r = $urandom_range(0, 99);
    sub = $urandom_range(0, 9);
    w.amount = rcp_pkg::AMT_W'($urandom);
    w.position = rcp_pkg::POS_W'($urandom);
    if (r < 4) begin
      w.mode = rcp_pkg::MODE_START;
    end else if (r < 8) begin
      w.mode = MODE_NONE;
    end else if (r < 40) begin
      w.mode = rcp_pkg::MODE_SHUFFLE;
      if (sub < 3) w.amount = '0;
      else if (sub < 8) w.amount = rcp_pkg::AMT_W'($urandom_range(1, 2 * h - 1));
      else if (sub < 9) w.amount = rcp_pkg::AMT_W'($urandom_range(2 * h, 511));
    end else begin
      w.mode = rcp_pkg::MODE_READ;
      if (sub < 8) w.position = rcp_pkg::POS_W'($urandom_range(0, 2 * h - 1));
    end
    return w;
  endfunction

  // driver
  int gap_left = 0;
  int burst_left = 0;
  deck_word_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) update_deck_model(mode, amount, position);
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          item_valid <= 1'b1;
          mode <= next_word.mode;
          amount <= next_word.amount;
          position <= next_word.position;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  logic [rcp_pkg::VAL_W-1:0] want_card;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      cards_seen <= cards_seen + 1;
      if (expected_cards.size() == 0) begin
        $error("card_value expected none actual %0d", card_value);
        error_count++;
      end else begin
        want_card = expected_cards.pop_front();
        if (card_value !== want_card) begin
          $error("card_value expected %0d actual %0d", want_card, card_value);
          error_count++;
        end
      end
    end
  end

  // receiver stall pattern with occasional long hold-off
  int hold_left = 0;
  int next_hold_at = 100;
  int pattern_left = 0;
  int stall_pct = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (cards_seen >= next_hold_at) begin
      next_hold_at = next_hold_at + 350;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(50, 200);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        pattern_left--;
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** riffle_and_cut_permuter: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || item_valid || expected_cards.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_count(logic [rcp_pkg::HC_W-1:0] v);
    @(posedge clk);
    half_count_we <= 1'b1;
    half_count_data <= v;
    @(posedge clk);
    half_count_we <= 1'b0;
    half_model = v;
  endtask

  initial begin
    logic [rcp_pkg::HC_W-1:0] phase_half[PHASE_COUNT];
    phase_half = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd128, 8'd5, 8'd100, 8'd127, 8'd0, 8'd0};
    phase_half[8] = rcp_pkg::HC_W'($urandom);
    phase_half[9] = rcp_pkg::HC_W'($urandom_range(1, 128));
    half_model = rcp_pkg::HC_RESET;
    load_identity();

    // full deck, starting on the reset identity order
    push_word(rcp_pkg::MODE_READ, 0, 0);
    push_word(rcp_pkg::MODE_READ, 511, 255);
    push_word(MODE_NONE, 511, 255);
    push_word(MODE_NONE, 0, 0);
    push_word(rcp_pkg::MODE_SHUFFLE, 0, 0);
    push_word(rcp_pkg::MODE_READ, 0, 1);
    push_word(rcp_pkg::MODE_READ, 0, 255);
    push_word(rcp_pkg::MODE_SHUFFLE, 1, 0);
    push_word(rcp_pkg::MODE_READ, 0, 0);
    push_word(rcp_pkg::MODE_SHUFFLE, 255, 255);
    push_word(rcp_pkg::MODE_READ, 0, 0);
    push_word(rcp_pkg::MODE_SHUFFLE, 256, 0);
    push_word(rcp_pkg::MODE_SHUFFLE, 511, 0);
    push_word(rcp_pkg::MODE_READ, 0, 128);
    push_word(rcp_pkg::MODE_START, 511, 255);
    push_word(rcp_pkg::MODE_READ, 0, 0);
    push_word(rcp_pkg::MODE_READ, 0, 200);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_half_count(phase_half[ph]);
      if (ph == 0) begin
        // smallest deck: reads past the end, cut by one, large cut, riffle
        push_word(rcp_pkg::MODE_READ, 0, 255);
        push_word(rcp_pkg::MODE_SHUFFLE, 1, 0);
        push_word(rcp_pkg::MODE_READ, 0, 0);
        push_word(rcp_pkg::MODE_SHUFFLE, 2, 0);
        push_word(rcp_pkg::MODE_SHUFFLE, 0, 0);
        push_word(rcp_pkg::MODE_READ, 0, 1);
      end
      for (int n = 0; n < PHASE_WORDS; n++) pending_words = {pending_words, random_deck_word()};
      wait_drained();
    end

    if (error_count == 0) begin
      $display("** riffle_and_cut_permuter: PASSED **");
    end else begin
      $display("** riffle_and_cut_permuter: FAILED **");
    end
    $finish;
  end

endmodule
